// File: design/nfba_pkg.sv
package nfba_pkg;

    // Width of the block-count register and its value after reset
    localparam int          CFG_W     = 5;
    localparam logic [4:0]  CFG_RESET = 5'd16;

    // Operation codes of an input word
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } t_state;

    // Controls from the sequencer to one cell
    typedef struct packed {
        logic inject;
        logic flush;
        logic is_last;
        logic we;
    } t_cell_ctl;

    // Status from one cell
    typedef struct packed {
        logic tok;
        logic hit;
        logic pass;
        logic wrap;
    } t_cell_stat;

endpackage

// File: design/next_fit_block_allocator_unit.sv
// Channel   Valid         Ready         Payload
// input     i_in_valid    o_in_ready    i_opcode, i_block_index, i_size_value
// output    o_out_valid   i_out_ready   o_granted, o_granted_block
// config    i_cfg_valid   o_cfg_ready   i_cfg_data (block count)
//
// A load word writes one block size and produces no output word.
// An allocate word walks a search token along the row of cells one block per cycle,
// visiting 1..block count blocks; no word is taken while a search or held result waits.
// Reset (synchronous, active low) clears the pointer, the token and the handshake state;
// block sizes are undefined until loaded.
// A finished result waits in a holding register while the output is stalled.
module next_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_opcode,
    input  logic [$clog2(MAX_BLOCKS)-1:0]  i_block_index,
    input  logic [SIZE_BITS-1:0]           i_size_value,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_granted,
    output logic [$clog2(MAX_BLOCKS)-1:0]  o_granted_block,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nfba_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = ($clog2(MAX_BLOCKS + 1) > nfba_pkg::CFG_W) ?
                           $clog2(MAX_BLOCKS + 1) : nfba_pkg::CFG_W;

    // Control registers
    nfba_pkg::t_state          r_state;
    nfba_pkg::t_state          n_state;
    logic [nfba_pkg::CFG_W-1:0] r_cfg;
    logic [IDX_W-1:0]          r_rover;
    logic [CNT_W-1:0]          r_step;
    logic                      r_out_vld;

    // Payload registers
    logic [SIZE_BITS-1:0]      r_req;
    logic                      r_granted;
    logic [IDX_W-1:0]          r_blk;
    logic                      r_pend_granted;
    logic [IDX_W-1:0]          r_pend_blk;

    // Cell row
    nfba_pkg::t_cell_ctl       cell_ctl  [MAX_BLOCKS];
    nfba_pkg::t_cell_stat      cell_stat [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0]     hit_vec;
    logic [MAX_BLOCKS-1:0]     wrap_vec;
    logic [MAX_BLOCKS-1:0]     tok_vec;

    logic [CNT_W-1:0]          cfg_ext;
    logic [CNT_W-1:0]          active_cnt;
    logic [CNT_W-1:0]          last_idx;
    logic [IDX_W-1:0]          start_idx;
    logic [IDX_W-1:0]          hit_idx;
    logic                      any_hit;

    logic                      in_acc;
    logic                      ld_en;
    logic                      inj_en;
    logic                      scan_fail;
    logic                      scan_done;
    logic                      out_free;

    // Block count: zero acts as one, anything past the row saturates
    always_comb begin
        cfg_ext = CNT_W'(r_cfg);
        if (r_cfg == '0) begin
            active_cnt = CNT_W'(1);
        end else if (cfg_ext > CNT_W'(MAX_BLOCKS)) begin
            active_cnt = CNT_W'(MAX_BLOCKS);
        end else begin
            active_cnt = cfg_ext;
        end
    end

    assign last_idx  = active_cnt - CNT_W'(1);
    // Restart at block zero when the count has shrunk to or below the pointer
    assign start_idx = (CNT_W'(r_rover) < active_cnt) ? r_rover : '0;

    assign o_cfg_ready = 1'b1;

    // Sequencer outputs
    always_comb begin
        o_in_ready = (r_state == nfba_pkg::ST_IDLE);
        in_acc     = i_in_valid & o_in_ready;
        ld_en      = in_acc & (i_opcode == nfba_pkg::OP_LOAD);
        inj_en     = in_acc & (i_opcode == nfba_pkg::OP_ALLOC);
        any_hit    = |hit_vec;
        scan_fail  = (r_state == nfba_pkg::ST_SCAN) & ~any_hit & (r_step == last_idx);
        scan_done  = (r_state == nfba_pkg::ST_SCAN) & (any_hit | scan_fail);
        out_free   = ~r_out_vld | i_out_ready;
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            nfba_pkg::ST_IDLE: begin
                if (inj_en) n_state = nfba_pkg::ST_SCAN;
            end
            nfba_pkg::ST_SCAN: begin
                if (scan_done) n_state = out_free ? nfba_pkg::ST_IDLE : nfba_pkg::ST_HOLD;
            end
            nfba_pkg::ST_HOLD: begin
                if (out_free) n_state = nfba_pkg::ST_IDLE;
            end
            default: n_state = nfba_pkg::ST_IDLE;
        endcase
    end

    // Row of cells; the token wraps from the last active cell back to cell zero
    genvar gi;
    generate
        for (gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
            logic tok_in;

            assign cell_ctl[gi].inject  = inj_en & (start_idx == IDX_W'(gi));
            assign cell_ctl[gi].flush   = scan_fail;
            assign cell_ctl[gi].is_last = (last_idx == CNT_W'(gi));
            assign cell_ctl[gi].we      = ld_en & (i_block_index == IDX_W'(gi));

            if (gi == 0) begin : g_head
                assign tok_in = |wrap_vec;
            end else begin : g_body
                assign tok_in = cell_stat[gi-1].pass;
            end

            nfba_cell #(
                .SIZE_BITS (SIZE_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl[gi]),
                .i_tok   (tok_in),
                .i_wdata (i_size_value),
                .i_req   (r_req),
                .o_stat  (cell_stat[gi])
            );

            assign hit_vec[gi]  = cell_stat[gi].hit;
            assign wrap_vec[gi] = cell_stat[gi].wrap;
            assign tok_vec[gi]  = cell_stat[gi].tok;
        end
    endgenerate

    // At most one cell hits, so OR the indexes together
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (hit_vec[i]) hit_idx = hit_idx | IDX_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= nfba_pkg::ST_IDLE;
            r_cfg     <= nfba_pkg::CFG_RESET;
            r_rover   <= '0;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
            // Load sends the pointer home, a hit parks it on the block
            if (ld_en) begin
                r_rover <= '0;
            end else if ((r_state == nfba_pkg::ST_SCAN) && any_hit) begin
                r_rover <= hit_idx;
            end
            if (inj_en) begin
                r_step <= '0;
            end else if (r_state == nfba_pkg::ST_SCAN) begin
                r_step <= r_step + CNT_W'(1);
            end
            if ((scan_done || (r_state == nfba_pkg::ST_HOLD)) && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (inj_en) begin
            r_req <= i_size_value;
        end
        if (scan_done) begin
            r_pend_granted <= any_hit;
            r_pend_blk     <= any_hit ? hit_idx : '0;
        end
        if (scan_done && out_free) begin
            r_granted <= any_hit;
            r_blk     <= any_hit ? hit_idx : '0;
        end else if ((r_state == nfba_pkg::ST_HOLD) && out_free) begin
            r_granted <= r_pend_granted;
            r_blk     <= r_pend_blk;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_granted       = r_granted;
    assign o_granted_block = r_blk;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vec))
        else $error("more than one search token in the row");

    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfba_pkg::ST_IDLE) |-> (tok_vec == '0))
        else $error("search token alive while idle");

    a_hit_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hit_vec != '0) |-> (r_state == nfba_pkg::ST_SCAN))
        else $error("cell hit outside a scan");

    a_scan_has_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == nfba_pkg::ST_SCAN) |-> $onehot(tok_vec))
        else $error("scan lost its token");

    a_fail_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_granted) |-> (o_granted_block == '0))
        else $error("failed request reports a nonzero block");
`endif

endmodule

// File: design/nfba_cell.sv
module nfba_cell #(
    parameter int SIZE_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nfba_pkg::t_cell_ctl      i_ctl,
    input  logic                     i_tok,
    input  logic [SIZE_BITS-1:0]     i_wdata,
    input  logic [SIZE_BITS-1:0]     i_req,
    output nfba_pkg::t_cell_stat     o_stat
);

    logic                 r_tok;
    logic [SIZE_BITS-1:0] r_rem;
    logic                 n_tok;
    logic                 hit;

    assign hit   = r_tok & (r_rem >= i_req);
    assign n_tok = i_ctl.inject | (i_tok & ~i_ctl.flush);

    assign o_stat.tok  = r_tok;
    assign o_stat.hit  = hit;
    assign o_stat.pass = r_tok & ~hit & ~i_ctl.is_last;
    assign o_stat.wrap = r_tok & ~hit & i_ctl.is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    // Remaining size: load overwrites, a hit takes the request out
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_rem <= i_wdata;
        end else if (hit) begin
            r_rem <= r_rem - i_req;
        end
    end

endmodule
